[rtl/lfpd_pkg.sv]
// Shared types and constants for the line-following PD steering block.
`default_nettype none
package lfpd_pkg;

	localparam int ErrW   = 16;
	localparam int DutyW  = 16;
	localparam int GainW  = 16;
	localparam int LevelW = 14;
	localparam int TickW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam int PProdW = GainW + 1 + ErrW;      // 33
	localparam int DProdW = GainW + 1 + ErrW + 1;  // 34
	localparam int SumW   = DProdW + 1;            // 35

	localparam logic signed [ErrW-1:0] CROSS_MARK  = 16'sd25600;
	localparam logic signed [ErrW-1:0] PIVOT_POS   = 16'sd12800;
	localparam logic signed [ErrW-1:0] PIVOT_NEG   = -16'sd12800;
	localparam logic signed [DutyW-1:0] DUTY_MAX   = 16'sd32767;

	localparam logic [GainW-1:0]  RST_PROP_GAIN  = 16'd1200;
	localparam logic [GainW-1:0]  RST_DERIV_GAIN = 16'd1100;
	localparam logic [LevelW-1:0] RST_BASE_DUTY  = 14'd3000;
	localparam logic [LevelW-1:0] RST_PIVOT_DUTY = 14'd4800;
	localparam logic [TickW-1:0]  RST_CROSS_TICKS = 8'd20;

	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BASE_DUTY   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PIVOT_DUTY  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CROSS_TICKS = 3'd4;

	typedef enum logic [1:0] {
		MODE_PD    = 2'd0,
		MODE_CROSS = 2'd1,
		MODE_PIVOT = 2'd2
	} drive_mode_t;

	typedef struct packed {
		logic [GainW-1:0]  prop_gain;
		logic [GainW-1:0]  deriv_gain;
		logic [LevelW-1:0] base_duty;
		logic [LevelW-1:0] pivot_duty;
		logic [TickW-1:0]  crossing_ticks;
	} lfpd_cfg_t;

	typedef struct packed {
		drive_mode_t              mode;
		logic signed [DutyW-1:0]  fix_left;
		logic signed [DutyW-1:0]  fix_right;
		logic signed [PProdW-1:0] p_prod;
		logic signed [DProdW-1:0] d_prod;
	} lfpd_mid_t;

endpackage
`default_nettype wire

[rtl/line_follow_pd_steering.sv]
// Top level of the line-following PD steering controller.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata[15:0] line_error
//  m_*     | out | m_tvalid/m_tready | tdata[15:0] left, [31:16] right; tuser[1:0] mode
//  cfg_*   | in  | cfg_we            | cfg_index, cfg_data
//
// One beat per cycle sustained while m_tready stays high; registers in order:
// input register, product register, result register. The two gain multipliers set the
// first stage, the PD sum and saturation the second.
// Reset clears all valid flags and controller state and loads the config defaults.
// Each stage holds while full and the next stage cannot take its beat.
`default_nettype none
module line_follow_pd_steering import lfpd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [15:0]         s_tdata,   // [15:0] line_error
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [31:0]              m_tdata,   // [15:0] left_duty, [31:16] right_duty
	output logic [1:0]               m_tuser,   // [1:0] drive_mode
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	lfpd_cfg_t              cfg_q;
	logic                   valid_s1;
	logic signed [ErrW-1:0] err_s1;
	logic                   valid_s2;
	lfpd_mid_t              mid_s2;
	logic                   valid_s3;
	logic [31:0]            data_s3;
	logic [1:0]             user_s3;

	logic                   rdy1;
	logic                   rdy2;
	logic                   rdy3;
	logic                   load2;
	logic signed [DutyW-1:0] left_duty;
	logic signed [DutyW-1:0] right_duty;
	drive_mode_t            drive_mode;

	assign rdy3     = !valid_s3 || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign load2    = valid_s1 && rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = valid_s3;
	assign m_tdata  = data_s3;
	assign m_tuser  = user_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= RST_PROP_GAIN;
			cfg_q.deriv_gain     <= RST_DERIV_GAIN;
			cfg_q.base_duty      <= RST_BASE_DUTY;
			cfg_q.pivot_duty     <= RST_PIVOT_DUTY;
			cfg_q.crossing_ticks <= RST_CROSS_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain      <= cfg_data[GainW-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain     <= cfg_data[GainW-1:0];
				REG_BASE_DUTY:   cfg_q.base_duty      <= cfg_data[LevelW-1:0];
				REG_PIVOT_DUTY:  cfg_q.pivot_duty     <= cfg_data[LevelW-1:0];
				REG_CROSS_TICKS: cfg_q.crossing_ticks <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			err_s1 <= signed'(s_tdata);
		end
		if (rdy3 && valid_s2) begin
			data_s3 <= {right_duty, left_duty};
			user_s3 <= drive_mode;
		end
	end

	lfpd_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load2),
		.err    (err_s1),
		.cfg    (cfg_q),
		.mid_s2 (mid_s2)
	);

	lfpd_finish u_finish (
		.mid        (mid_s2),
		.base_duty  (cfg_q.base_duty),
		.left_duty  (left_duty),
		.right_duty (right_duty),
		.drive_mode (drive_mode)
	);

endmodule
`default_nettype wire

[rtl/lfpd_decide.sv]
// First stage: mode decision, controller state and the two gain products.
`default_nettype none
module lfpd_decide import lfpd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic signed [ErrW-1:0] err,
	input  wire lfpd_cfg_t              cfg,
	output lfpd_mid_t                   mid_s2
);

	logic [TickW-1:0]       cross_cnt_q;
	logic signed [ErrW-1:0] prev_err_q;

	logic [TickW-1:0]       cnt;
	logic [TickW-1:0]       cnt_next;
	logic signed [ErrW-1:0] prev_next;
	logic signed [ErrW:0]   diff;
	logic signed [DutyW-1:0] base_s;
	logic signed [DutyW-1:0] pivot_s;
	lfpd_mid_t              mid;

	always_comb begin
		cnt       = (err == CROSS_MARK) ? cfg.crossing_ticks : cross_cnt_q;
		cnt_next  = cnt;
		prev_next = prev_err_q;
		base_s    = signed'({2'b00, cfg.base_duty});
		pivot_s   = signed'({2'b00, cfg.pivot_duty});
		diff      = signed'({err[ErrW-1], err} - {prev_err_q[ErrW-1], prev_err_q});
		mid.p_prod = PProdW'(signed'({1'b0, cfg.prop_gain})) * PProdW'(err);
		mid.d_prod = DProdW'(signed'({1'b0, cfg.deriv_gain})) * DProdW'(diff);
		if (cnt != '0) begin
			mid.mode      = MODE_CROSS;
			mid.fix_left  = base_s;
			mid.fix_right = base_s;
			cnt_next      = cnt - TickW'(1);
		end else if (err >= PIVOT_POS || err <= PIVOT_NEG) begin
			mid.mode = MODE_PIVOT;
			if (err <= PIVOT_NEG) begin
				mid.fix_left  = -pivot_s;
				mid.fix_right = pivot_s;
			end else begin
				mid.fix_left  = pivot_s;
				mid.fix_right = -pivot_s;
			end
		end else begin
			mid.mode      = MODE_PD;
			mid.fix_left  = base_s;
			mid.fix_right = base_s;
			prev_next     = err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_cnt_q <= '0;
			prev_err_q  <= '0;
		end else if (load) begin
			cross_cnt_q <= cnt_next;
			prev_err_q  <= prev_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mid_s2 <= mid;
		end
	end

endmodule
`default_nettype wire

[rtl/lfpd_finish.sv]
// Second stage: PD sum, truncating scale, base offset and saturation in PD mode; other modes pass the fixed duties.
`default_nettype none
module lfpd_finish import lfpd_pkg::*; (
	input  wire lfpd_mid_t              mid,
	input  wire logic [LevelW-1:0]      base_duty,
	output logic signed [DutyW-1:0]     left_duty,
	output logic signed [DutyW-1:0]     right_duty,
	output drive_mode_t                 drive_mode
);

	localparam int CorrW = SumW - 8;
	localparam int WideW = CorrW + 1;

	logic signed [SumW-1:0]  sum;
	logic signed [SumW-1:0]  biased;
	logic signed [CorrW-1:0] corr;
	logic signed [WideW-1:0] base_w;
	logic signed [WideW-1:0] l_w;
	logic signed [WideW-1:0] r_w;

	function automatic logic signed [DutyW-1:0] sat(input logic signed [WideW-1:0] v);
		logic signed [WideW-1:0] hi;
		logic signed [WideW-1:0] lo;
		hi = WideW'(DUTY_MAX);
		lo = -hi;
		if (v > hi)
			sat = DUTY_MAX;
		else if (v < lo)
			sat = -DUTY_MAX;
		else
			sat = v[DutyW-1:0];
	endfunction

	always_comb begin
		sum    = SumW'(mid.p_prod) + SumW'(mid.d_prod);
		biased = sum + (sum[SumW-1] ? SumW'(255) : SumW'(0));
		corr   = CorrW'(biased >>> 8);
		base_w = signed'(WideW'({1'b0, base_duty}));
		l_w    = base_w + WideW'(corr);
		r_w    = base_w - WideW'(corr);
		drive_mode = mid.mode;
		if (mid.mode == MODE_PD) begin
			left_duty  = sat(l_w);
			right_duty = sat(r_w);
		end else begin
			left_duty  = mid.fix_left;
			right_duty = mid.fix_right;
		end
	end

endmodule
`default_nettype wire
